// ===== rtl/wmlb_pkg.sv =====
// Package: shared constants, types and widths for the windowed-minimum baseline block.
`default_nettype none
package wmlb_pkg;
    localparam int unsigned RING_DEPTH_DEF    = 64;
    localparam int unsigned PENDING_LIMIT_DEF = 32;
    localparam logic [31:0] WINDOW_RESET      = 32'd131072;

    typedef struct packed {
        logic [31:0] point_x;
        logic signed [31:0] point_y;
        logic        last_point;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] out_x;
        logic signed [31:0] baseline_y;
        logic        window_truncated;
        logic        last_result;
    } t_out_beat;

    // Divider request/response between the top level and the divider.
    typedef struct packed {
        logic               start;
        logic signed [64:0] num;
        logic [32:0]        den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic signed [31:0] quot;
    } t_div_rsp;
endpackage
`default_nettype wire

// ===== rtl/wmlb_if.sv =====
// Interfaces: valid/ready channels carrying input and result beats.
`default_nettype none
interface wmlb_in_if;
    logic               valid;
    logic               ready;
    wmlb_pkg::t_in_beat data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface wmlb_out_if;
    logic                valid;
    logic                ready;
    wmlb_pkg::t_out_beat data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/wmlb_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module wmlb_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/wmlb_div.sv =====
// Restoring signed divider, one quotient bit per cycle, truncates toward zero.
`default_nettype none
module wmlb_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire wmlb_pkg::t_div_req i_req,
    output      wmlb_pkg::t_div_rsp o_rsp
);
    logic [64:0] r_rem;
    logic [64:0] r_quo;
    logic [32:0] r_den;
    logic        r_neg;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [65:0] n_trial;
    logic [64:0] n_rem;
    logic [64:0] abs_num;
    logic [64:0] quo_s;

    assign abs_num = i_req.num[64] ? 65'(-i_req.num) : i_req.num;
    assign n_rem   = {r_rem[63:0], r_quo[64]};
    assign n_trial = {1'b0, n_rem} - {33'd0, r_den};
    assign quo_s   = r_neg ? 65'(-r_quo) : r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd65;
                r_rem  <= '0;
                r_quo  <= abs_num;
                r_den  <= i_req.den;
                r_neg  <= i_req.num[64];
            end else if (r_busy) begin
                if (n_trial[65]) begin
                    r_rem <= n_rem;
                    r_quo <= {r_quo[63:0], 1'b0};
                end else begin
                    r_rem <= n_trial[64:0];
                    r_quo <= {r_quo[63:0], 1'b1};
                end
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = quo_s[31:0];
endmodule
`default_nettype wire

// ===== rtl/windowed_minimum_linear_baseline.sv =====
// Top level: ring-buffered windowed-minimum linear baseline.
// channel | dir | payload
// i_in    | in  | point_x, point_y, last_point
// o_out   | out | out_x, baseline_y, window_truncated, last_result
// cfg     | in  | i_cfg_we, i_cfg_data (window_width)
// An input beat passes through accept, pending check (registered RAM read), store.
// Each result adds a left and a right scan that together read at most RING_DEPTH
// entries, one per cycle, plus the divide when interpolating.
// Reset (synchronous) clears pointers and counts; ring contents are not cleared.
// A result waits in the output register; the next one is computed meanwhile.
`default_nettype none
module windowed_minimum_linear_baseline #(
    parameter int unsigned RING_DEPTH    = wmlb_pkg::RING_DEPTH_DEF,
    parameter int unsigned PENDING_LIMIT = wmlb_pkg::PENDING_LIMIT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    wmlb_in_if.sink          i_in,
    wmlb_out_if.source       o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_data
);
    localparam int unsigned AW  = $clog2(RING_DEPTH);
    localparam int unsigned CW  = $clog2(RING_DEPTH + 1);
    localparam int unsigned CAP = (PENDING_LIMIT < RING_DEPTH) ? PENDING_LIMIT : RING_DEPTH;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_CHK   = 10'b0000000010,
        S_STORE = 10'b0000000100,
        S_PREP  = 10'b0000001000,
        S_LEFT  = 10'b0000010000,
        S_RIGHT = 10'b0000100000,
        S_CALC  = 10'b0001000000,
        S_DIV   = 10'b0010000000,
        S_OUT   = 10'b0100000000,
        S_NEXT  = 10'b1000000000
    } t_state;

    t_state r_state;
    logic [31:0] r_win;
    logic [AW-1:0] r_wp;
    logic [CW-1:0] r_stored, r_pend;
    logic [31:0] r_x;
    logic [31:0] r_y;
    logic        r_last;
    logic        r_cut;       // forced emission by pending overflow
    logic        r_flush;
    logic        r_chk_wait;
    // scan state
    logic [CW-1:0] r_age;     // age being read
    logic        r_rd_vld;
    logic        r_pv;        // have px/py
    logic [31:0] r_px;
    logic signed [31:0] r_py;
    logic [31:0] r_lx, r_rx;
    logic signed [31:0] r_ly, r_ry;
    logic        r_lf, r_rf, r_tr;
    logic [CW-1:0] r_lastage;
    logic        r_done_scan;
    logic        r_ovld;
    logic signed [31:0] r_base;
    wmlb_pkg::t_out_beat r_obeat;
    wmlb_pkg::t_div_req  div_req;
    wmlb_pkg::t_div_rsp  div_rsp;

    logic [31:0] rd_x, rd_y;
    logic [AW-1:0] raddr;
    logic        we;
    logic [31:0] d_half;
    logic [32:0] hi;
    logic signed [33:0] lo;
    logic [CW-1:0] a_old;

    assign d_half = {1'b0, r_win[31:1]};
    assign a_old  = r_pend - CW'(1);
    assign hi     = {1'b0, r_px} + {1'b0, d_half};
    assign lo     = $signed({2'b0, r_px}) - $signed({2'b0, d_half});

    // slot of age a: wp - 1 - a mod depth
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] wp, input logic [CW-1:0] a);
        logic [CW+1:0] t;
        t = (CW+2)'(wp) + (CW+2)'(2 * RING_DEPTH - 1) - (CW+2)'(a);
        if (t >= (CW+2)'(2 * RING_DEPTH)) t = t - (CW+2)'(2 * RING_DEPTH);
        if (t >= (CW+2)'(RING_DEPTH)) t = t - (CW+2)'(RING_DEPTH);
        return AW'(t);
    endfunction

    assign we = (r_state == S_STORE);
    always_comb begin
        raddr = slot(r_wp, (r_state == S_PREP) ? a_old : r_age);
    end

    wmlb_ram #(.WIDTH(32), .DEPTH(RING_DEPTH)) u_ram_x (
        .i_clk(i_clk), .i_we(we), .i_waddr(r_wp), .i_wdata(r_x),
        .i_raddr(raddr), .o_rdata(rd_x)
    );
    wmlb_ram #(.WIDTH(32), .DEPTH(RING_DEPTH)) u_ram_y (
        .i_clk(i_clk), .i_we(we), .i_waddr(r_wp), .i_wdata(r_y),
        .i_raddr(raddr), .o_rdata(rd_y)
    );

    wmlb_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));

    logic signed [31:0] ry_s;
    assign ry_s = $signed(rd_y);

    logic [32:0] dl, dr;
    assign dl = {1'b0, r_px} - {1'b0, r_lx};
    assign dr = {1'b0, r_rx} - {1'b0, r_px};
    logic signed [64:0] r_p1, r_p2;

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_ovld;
    assign o_out.data  = r_obeat;

    logic out_free;
    assign out_free = !r_ovld || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_win   <= wmlb_pkg::WINDOW_RESET;
            r_wp    <= '0;
            r_stored <= '0;
            r_pend  <= '0;
            r_ovld  <= 1'b0;
            r_rd_vld <= 1'b0;
            div_req.start <= 1'b0;
        end else begin
            div_req.start <= 1'b0;
            if (r_ovld && o_out.ready) r_ovld <= 1'b0;
            if (i_cfg_we) r_win <= i_cfg_data;
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_x <= i_in.data.point_x;
                        r_y <= i_in.data.point_y;
                        r_last <= i_in.data.last_point;
                        r_flush <= 1'b0;
                        r_state <= S_CHK;
                        r_chk_wait <= 1'b1;
                        r_age <= r_pend - CW'(1);
                    end
                end
                S_CHK: begin
                    // read oldest pending x, compare with new x
                    if (r_pend == '0) begin
                        r_state <= S_STORE;
                    end else if (r_chk_wait) begin
                        r_chk_wait <= 1'b0;
                    end else if ({1'b0, rd_x} + {1'b0, d_half} < {1'b0, r_x}) begin
                        r_cut <= 1'b0;
                        r_state <= S_PREP;
                    end else begin
                        r_state <= S_STORE;
                    end
                end
                S_STORE: begin
                    r_wp <= (r_wp == AW'(RING_DEPTH - 1)) ? '0 : r_wp + AW'(1);
                    if (r_stored < CW'(RING_DEPTH)) r_stored <= r_stored + CW'(1);
                    r_pend <= r_pend + CW'(1);
                    if (r_last) begin
                        r_flush <= 1'b1;
                        r_cut <= 1'b0;
                        r_state <= S_PREP;
                    end else if (r_pend + CW'(1) >= CW'(CAP)) begin
                        r_cut <= 1'b1;
                        r_state <= S_PREP;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_PREP: begin
                    // the point itself is read this cycle; the scan continues one age up
                    r_age <= a_old + CW'(1);
                    r_rd_vld <= 1'b1;
                    r_pv <= 1'b0;
                    r_lf <= 1'b0; r_rf <= 1'b0;
                    r_tr <= r_cut;
                    r_done_scan <= 1'b0;
                    r_state <= S_LEFT;
                end
                S_LEFT: begin
                    // issue reads at increasing age; first read returns the point itself
                    if (!r_done_scan && r_age + CW'(1) < r_stored)
                        r_age <= r_age + CW'(1);
                    else
                        r_rd_vld <= 1'b0;
                    r_lastage <= r_age;
                    if (!r_pv) begin
                        r_pv <= 1'b1;
                        r_px <= rd_x; r_py <= ry_s;
                        r_lx <= rd_x; r_ly <= ry_s;
                        r_rx <= rd_x; r_ry <= ry_s;
                        if (!(a_old + CW'(1) < r_stored)) begin
                            if (r_stored >= CW'(RING_DEPTH)) r_tr <= 1'b1;
                            r_done_scan <= 1'b1;
                        end
                    end else if (!r_done_scan) begin
                        if ($signed({2'b0, rd_x}) < lo) begin
                            r_done_scan <= 1'b1;
                        end else begin
                            if (ry_s < r_ly) begin
                                r_lx <= rd_x; r_ly <= ry_s; r_lf <= 1'b1;
                            end
                            if (!(r_lastage + CW'(1) < r_stored)) begin
                                if (r_stored >= CW'(RING_DEPTH)) r_tr <= 1'b1;
                                r_done_scan <= 1'b1;
                            end
                        end
                    end
                    if (r_pv && (r_done_scan || !r_rd_vld)) begin
                        r_done_scan <= (a_old == '0);
                        r_age <= a_old - CW'(1);
                        r_pv <= 1'b0;
                        r_state <= S_RIGHT;
                    end
                end
                S_RIGHT: begin
                    // r_pv marks read data valid
                    r_lastage <= r_age;
                    if (!r_done_scan) begin
                        if (r_pv) begin
                            if ({1'b0, rd_x} > hi) begin
                                r_done_scan <= 1'b1;
                            end else begin
                                if (ry_s < r_ry) begin
                                    r_rx <= rd_x; r_ry <= ry_s; r_rf <= 1'b1;
                                end
                                if (r_lastage == '0) r_done_scan <= 1'b1;
                            end
                        end
                        r_pv <= 1'b1;
                        if (r_age != '0) r_age <= r_age - CW'(1);
                    end else begin
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    if (r_lf && r_rf && r_lx != r_rx && r_lx <= r_px && r_rx >= r_px) begin
                        r_p1 <= $signed({32'd0, dr}) * 65'(r_ly);
                        r_p2 <= $signed({32'd0, dl}) * 65'(r_ry);
                        r_state <= S_DIV;
                        r_pv <= 1'b0;
                    end else begin
                        r_base <= r_py;
                        r_state <= S_OUT;
                    end
                end
                S_DIV: begin
                    if (!r_pv) begin
                        r_pv <= 1'b1;
                        div_req.start <= 1'b1;
                        div_req.num <= r_p1 + r_p2;
                        div_req.den <= dl + dr;
                    end else if (div_rsp.done) begin
                        r_base <= div_rsp.quot;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_ovld <= 1'b1;
                        r_obeat.out_x <= r_px;
                        r_obeat.baseline_y <= r_base;
                        r_obeat.window_truncated <= r_tr;
                        r_obeat.last_result <= r_flush && (r_pend == CW'(1));
                        r_pend <= r_pend - CW'(1);
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (r_flush) begin
                        if (r_pend == '0) begin
                            r_wp <= '0; r_stored <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_PREP;
                        end
                    end else if (r_cut) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_age <= r_pend - CW'(1);
                        r_chk_wait <= 1'b1;
                        r_state <= S_CHK;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= CW'(CAP))
        else $error("pending count over capacity");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && !o_out.ready) |=> r_ovld)
        else $error("result dropped while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && !o_out.ready) |=> $stable(r_obeat))
        else $error("result beat changed while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !div_req.start)
        else $error("divide started while idle");
endmodule
`default_nettype wire
